FILE: rtl/ac_pkg.sv
`timescale 1ns / 1ps

package ac_pkg;

   localparam int DEF_MAX_NODES     = 256;
   localparam int DEF_MAX_SYMBOLS   = 16;
   localparam int DEF_MAX_PATTERNS  = 16;
   localparam int DEF_POSITION_BITS = 32;

   localparam int BYTE_VALUES = 256;
   localparam int RESULT_CAP  = 16;
   localparam int RCNT_W      = $clog2(RESULT_CAP);

   localparam logic [2:0] CMD_ALPHABET = 3'd0;
   localparam logic [2:0] CMD_PATTERN  = 3'd1;
   localparam logic [2:0] CMD_END      = 3'd2;
   localparam logic [2:0] CMD_BUILD    = 3'd3;
   localparam logic [2:0] CMD_RESTART  = 3'd4;
   localparam logic [2:0] CMD_TEXT     = 3'd5;

   localparam logic [1:0] KIND_MATCH    = 2'd0;
   localparam logic [1:0] KIND_NOT_SYM  = 2'd1;
   localparam logic [1:0] KIND_CAPACITY = 2'd2;
   localparam logic [1:0] KIND_ORDER    = 2'd3;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  pattern_id;
      logic [31:0] start_position;
      logic        last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_PB_CHECK,
      ST_EP_WRITE,
      ST_TX_STEP,
      ST_WALK,
      ST_EMIT,
      ST_B_POP,
      ST_B_PARENT,
      ST_B_SUFP,
      ST_B_LNK_RD,
      ST_B_LNK,
      ST_B_DICT,
      ST_B_CHILD_RD,
      ST_B_CHILD_CHK,
      ST_B_FILL
   } state_type;

endpackage

FILE: rtl/aho_corasick_matcher_top.sv
`timescale 1ns / 1ps

// aho-corasick multi-pattern byte matcher
// request channel: a command beat (req_data) is taken on a clock edge with start high
// and busy low; commands define the alphabet, feed and close patterns, build the
// automaton, restart the text or feed one text byte
// result channel: rsp_valid marks a beat on rsp_data for exactly one cycle; the
// receiver cannot stall, so results go out as they are found
// a text byte passes the decode and goto step states and goes back to idle when the
// goto step lands on the root; otherwise it walks the node and each dictionary link
// followed, emitting one beat per match, RESULT_CAP beats at most; the goto and
// pattern-mask memories are read through registered ports; a new command is taken only once busy is low again
// build walks the trie breadth first, visiting every node and each of its goto
// entries (MAX_NODES * MAX_SYMBOLS entries at most)
// errors give one beat with last set and change no state
// reset: after reset goes low the block clears the goto table and pattern masks,
// one entry a cycle, with busy high
module aho_corasick_matcher_top
   import ac_pkg::*;
#(
   parameter int MAX_NODES     = DEF_MAX_NODES,
   parameter int MAX_SYMBOLS   = DEF_MAX_SYMBOLS,
   parameter int MAX_PATTERNS  = DEF_MAX_PATTERNS,
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int NCNT_W     = NODE_W + 1;
   localparam int SYM_W      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int SCNT_W     = $clog2(MAX_SYMBOLS + 1);
   localparam int PID_W      = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int PCNT_W     = $clog2(MAX_PATTERNS + 1);
   localparam int GOTO_DEPTH = MAX_NODES * MAX_SYMBOLS;
   localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
   localparam int GOTO_W     = NODE_W + 1;
   localparam int PAR_W      = NODE_W + SYM_W;

   // goto entry: valid bit over child node
   function automatic logic [GOTO_AW-1:0] goto_addr(input logic [NODE_W-1:0] n,
                                                    input logic [SYM_W-1:0] s);
      return GOTO_AW'(GOTO_AW'(n) * GOTO_AW'(MAX_SYMBOLS) + GOTO_AW'(s));
   endfunction

   function automatic logic [PID_W-1:0] lowest_id(input logic [MAX_PATTERNS-1:0] m);
      logic [PID_W-1:0] id;
      id = '0;
      for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
         if (m[i]) id = PID_W'(i);
      end
      return id;
   endfunction

   // control state
   state_type                   state_ff, state_in;
   logic [GOTO_AW-1:0]          clr_ff, clr_in;
   logic [BYTE_VALUES-1:0]      sym_valid_ff, sym_valid_in;
   logic [SCNT_W-1:0]           sym_count_ff, sym_count_in;
   logic [NCNT_W-1:0]           node_count_ff, node_count_in;
   logic [PCNT_W-1:0]           pat_count_ff, pat_count_in;
   logic [NODE_W-1:0]           ins_node_ff, ins_node_in;
   logic [NODE_W-1:0]           ins_len_ff, ins_len_in;
   logic                        built_ff, built_in;
   logic [NODE_W-1:0]           auto_ff, auto_in;
   logic [POSITION_BITS-1:0]    pos_ff, pos_in;
   logic [NCNT_W-1:0]           head_ff, head_in;
   logic [NCNT_W-1:0]           tail_ff, tail_in;
   logic [RCNT_W-1:0]           rcnt_ff, rcnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // payload
   logic [2:0]                  cmd_ff, cmd_in;
   logic [7:0]                  val_ff, val_in;
   logic [SYM_W-1:0]            sym_ff, sym_in;
   logic [NODE_W-1:0]           cur_ff, cur_in;
   logic [NODE_W-1:0]           lnk_ff, lnk_in;
   logic [SCNT_W-1:0]           idx_ff, idx_in;
   logic [MAX_PATTERNS-1:0]     walk_mask_ff, walk_mask_in;
   logic [NODE_W-1:0]           walk_dict_ff, walk_dict_in;
   logic [NODE_W-1:0]           plen_ff [MAX_PATTERNS];
   logic                        plen_we;
   rsp_type                     rsp_ff, rsp_in;

   // memory ports
   logic                        sym_we;
   logic [SYM_W-1:0]            sym_rdata;
   logic                        goto_we;
   logic [GOTO_AW-1:0]          goto_waddr, goto_raddr;
   logic [GOTO_W-1:0]           goto_wdata, goto_rdata;
   logic                        par_we;
   logic [PAR_W-1:0]            par_rdata;
   logic                        link_we;
   logic [NODE_W-1:0]           suf_wdata, dict_wdata, suf_rdata, dict_rdata;
   logic [NODE_W-1:0]           suf_raddr, nd_raddr;
   logic                        mask_we;
   logic [NODE_W-1:0]           mask_waddr;
   logic [MAX_PATTERNS-1:0]     mask_wdata, mask_rdata;
   logic                        q_we;
   logic [NODE_W-1:0]           q_waddr, q_wdata, q_raddr, q_rdata;
   logic [7:0]                  sym_raddr;

   // shared decode
   logic                        known;
   logic [NODE_W-1:0]           goto_child;
   logic                        goto_valid;
   logic [NODE_W-1:0]           par_node;
   logic [SYM_W-1:0]            par_sym;
   logic [PID_W-1:0]            emit_id;
   logic [MAX_PATTERNS-1:0]     emit_rest;
   logic                        emit_last;
   logic [POSITION_BITS-1:0]    emit_start;
   logic [63:0]                 emit_start_wide;
   logic [7:0]                  emit_id_wide;
   logic                        link_needed;

   assign known       = sym_valid_ff[val_ff];
   assign goto_child  = goto_rdata[NODE_W-1:0];
   assign goto_valid  = goto_rdata[NODE_W];
   assign par_node    = par_rdata[PAR_W-1:SYM_W];
   assign par_sym     = par_rdata[SYM_W-1:0];
   assign link_needed = (cur_ff != '0) && (par_node != '0);

   assign emit_id         = lowest_id(walk_mask_ff);
   assign emit_rest       = walk_mask_ff & ~(MAX_PATTERNS'(1) << emit_id);
   assign emit_last       = ((emit_rest == '0) && (walk_dict_ff == '0)) ||
                            (rcnt_ff == RCNT_W'(RESULT_CAP - 1));
   assign emit_start      = pos_ff - POSITION_BITS'(plen_ff[emit_id]) + POSITION_BITS'(1);
   assign emit_start_wide = 64'(emit_start);
   assign emit_id_wide    = 8'(emit_id);

   // symbol map: byte -> symbol index, validity kept in flops
   ac_ram #(.WIDTH(SYM_W), .DEPTH(BYTE_VALUES)) u_sym_ram (
      .clock, .wr_en(sym_we), .wr_addr(val_ff), .wr_data(SYM_W'(sym_count_ff)),
      .rd_addr(sym_raddr), .rd_data(sym_rdata)
   );

   ac_ram #(.WIDTH(GOTO_W), .DEPTH(GOTO_DEPTH)) u_goto_ram (
      .clock, .wr_en(goto_we), .wr_addr(goto_waddr), .wr_data(goto_wdata),
      .rd_addr(goto_raddr), .rd_data(goto_rdata)
   );

   ac_ram #(.WIDTH(PAR_W), .DEPTH(MAX_NODES)) u_par_ram (
      .clock, .wr_en(par_we), .wr_addr(node_count_ff[NODE_W-1:0]),
      .wr_data({ins_node_ff, sym_ff}), .rd_addr(q_rdata), .rd_data(par_rdata)
   );

   ac_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_suf_ram (
      .clock, .wr_en(link_we), .wr_addr(cur_ff), .wr_data(suf_wdata),
      .rd_addr(suf_raddr), .rd_data(suf_rdata)
   );

   ac_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_dict_ram (
      .clock, .wr_en(link_we), .wr_addr(cur_ff), .wr_data(dict_wdata),
      .rd_addr(nd_raddr), .rd_data(dict_rdata)
   );

   ac_ram #(.WIDTH(MAX_PATTERNS), .DEPTH(MAX_NODES)) u_mask_ram (
      .clock, .wr_en(mask_we), .wr_addr(mask_waddr), .wr_data(mask_wdata),
      .rd_addr(nd_raddr), .rd_data(mask_rdata)
   );

   ac_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
      .clock, .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == GOTO_AW'(GOTO_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (cmd_ff)
               CMD_PATTERN: state_in = (!built_ff && known) ? ST_PB_CHECK : ST_IDLE;
               CMD_END: begin
                  state_in = (!built_ff && pat_count_ff < PCNT_W'(MAX_PATTERNS)) ?
                             ST_EP_WRITE : ST_IDLE;
               end
               CMD_BUILD: state_in = (!built_ff && ins_len_ff == '0) ? ST_B_POP : ST_IDLE;
               CMD_TEXT:  state_in = (built_ff && known) ? ST_TX_STEP : ST_IDLE;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_PB_CHECK, ST_EP_WRITE: state_in = ST_IDLE;
         ST_TX_STEP: state_in = (goto_child == '0) ? ST_IDLE : ST_WALK;
         ST_WALK: begin
            if (mask_rdata != '0)      state_in = ST_EMIT;
            else if (dict_rdata == '0) state_in = ST_IDLE;
            else                       state_in = ST_WALK;
         end
         ST_EMIT: begin
            if (emit_last)             state_in = ST_IDLE;
            else if (emit_rest == '0)  state_in = ST_WALK;
            else                       state_in = ST_EMIT;
         end
         ST_B_POP:    state_in = (head_ff < tail_ff) ? ST_B_PARENT : ST_IDLE;
         ST_B_PARENT: state_in = ST_B_SUFP;
         ST_B_SUFP:   state_in = link_needed ? ST_B_LNK_RD : ST_B_CHILD_RD;
         ST_B_LNK_RD: state_in = ST_B_LNK;
         ST_B_LNK:    state_in = (goto_child == '0) ? ST_B_CHILD_RD : ST_B_DICT;
         ST_B_DICT:   state_in = ST_B_CHILD_RD;
         ST_B_CHILD_RD: begin
            state_in = (idx_ff < sym_count_ff) ? ST_B_CHILD_CHK : ST_B_POP;
         end
         ST_B_CHILD_CHK: begin
            state_in = (goto_valid || cur_ff == '0) ? ST_B_CHILD_RD : ST_B_FILL;
         end
         ST_B_FILL: state_in = ST_B_CHILD_RD;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in        = clr_ff;
      sym_valid_in  = sym_valid_ff;
      sym_count_in  = sym_count_ff;
      node_count_in = node_count_ff;
      pat_count_in  = pat_count_ff;
      ins_node_in   = ins_node_ff;
      ins_len_in    = ins_len_ff;
      built_in      = built_ff;
      auto_in       = auto_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rcnt_in       = rcnt_ff;
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      sym_in        = sym_ff;
      cur_in        = cur_ff;
      lnk_in        = lnk_ff;
      idx_in        = idx_ff;
      walk_mask_in  = walk_mask_ff;
      walk_dict_in  = walk_dict_ff;
      plen_we       = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      sym_raddr     = req_data.value;
      sym_we        = 1'b0;
      goto_we       = 1'b0;
      goto_waddr    = goto_addr(cur_ff, SYM_W'(idx_ff));
      goto_wdata    = '0;
      goto_raddr    = goto_addr(ins_node_ff, sym_rdata);
      par_we        = 1'b0;
      link_we       = 1'b0;
      suf_wdata     = '0;
      dict_wdata    = '0;
      suf_raddr     = par_node;
      nd_raddr      = goto_child;
      mask_we       = 1'b0;
      mask_waddr    = ins_node_ff;
      mask_wdata    = mask_rdata | (MAX_PATTERNS'(1) << pat_count_ff);
      q_we          = 1'b0;
      q_waddr       = tail_ff[NODE_W-1:0];
      q_wdata       = goto_child;
      q_raddr       = head_ff[NODE_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep goto entries to absent and masks to zero
            goto_we    = 1'b1;
            goto_waddr = clr_ff;
            goto_wdata = '0;
            mask_we    = (32'(clr_ff) < MAX_NODES);
            mask_waddr = clr_ff[NODE_W-1:0];
            mask_wdata = '0;
            clr_in     = clr_ff + GOTO_AW'(1);
         end
         ST_IDLE: begin
            cmd_in = req_data.command;
            val_in = req_data.value;
         end
         ST_DECODE: begin
            rsp_in = '{kind: KIND_ORDER, pattern_id: '0, start_position: '0, last: 1'b1};
            sym_in = sym_rdata;
            unique case (cmd_ff)
               CMD_ALPHABET: begin
                  if (built_ff) begin
                     rsp_valid_in = 1'b1;
                  end else if (!known) begin
                     if (sym_count_ff >= SCNT_W'(MAX_SYMBOLS)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.kind  = KIND_CAPACITY;
                     end else begin
                        sym_we               = 1'b1;
                        sym_valid_in[val_ff] = 1'b1;
                        sym_count_in         = sym_count_ff + SCNT_W'(1);
                     end
                  end
               end
               CMD_PATTERN: begin
                  goto_raddr = goto_addr(ins_node_ff, sym_rdata);
                  if (built_ff) begin
                     rsp_valid_in = 1'b1;
                  end else if (!known) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.kind  = KIND_NOT_SYM;
                  end
               end
               CMD_END: begin
                  nd_raddr = ins_node_ff;
                  if (built_ff) begin
                     rsp_valid_in = 1'b1;
                  end else if (pat_count_ff >= PCNT_W'(MAX_PATTERNS)) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.kind  = KIND_CAPACITY;
                  end
               end
               CMD_BUILD: begin
                  if (built_ff || ins_len_ff != '0) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     // root seeds the breadth-first queue
                     q_we    = 1'b1;
                     q_waddr = '0;
                     q_wdata = '0;
                     head_in = '0;
                     tail_in = NCNT_W'(1);
                  end
               end
               CMD_RESTART: begin
                  auto_in = '0;
                  pos_in  = '0;
               end
               CMD_TEXT: begin
                  goto_raddr = goto_addr(auto_ff, sym_rdata);
                  if (!built_ff) begin
                     rsp_valid_in = 1'b1;
                  end else if (!known) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.kind  = KIND_NOT_SYM;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         ST_PB_CHECK: begin
            rsp_in = '{kind: KIND_CAPACITY, pattern_id: '0, start_position: '0, last: 1'b1};
            if (goto_valid) begin
               ins_node_in = goto_child;
               ins_len_in  = ins_len_ff + NODE_W'(1);
            end else if (node_count_ff >= NCNT_W'(MAX_NODES)) begin
               rsp_valid_in = 1'b1;
            end else begin
               goto_we       = 1'b1;
               goto_waddr    = goto_addr(ins_node_ff, sym_ff);
               goto_wdata    = {1'b1, node_count_ff[NODE_W-1:0]};
               par_we        = 1'b1;
               ins_node_in   = node_count_ff[NODE_W-1:0];
               node_count_in = node_count_ff + NCNT_W'(1);
               ins_len_in    = ins_len_ff + NODE_W'(1);
            end
         end
         ST_EP_WRITE: begin
            mask_we      = 1'b1;
            plen_we      = 1'b1;
            pat_count_in = pat_count_ff + PCNT_W'(1);
            ins_node_in  = '0;
            ins_len_in   = '0;
         end
         ST_TX_STEP: begin
            auto_in  = goto_child;
            nd_raddr = goto_child;
            rcnt_in  = '0;
            if (goto_child == '0) pos_in = pos_ff + POSITION_BITS'(1);
         end
         ST_WALK: begin
            walk_mask_in = mask_rdata;
            walk_dict_in = dict_rdata;
            nd_raddr     = dict_rdata;
            if (mask_rdata == '0 && dict_rdata == '0) pos_in = pos_ff + POSITION_BITS'(1);
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{kind: KIND_MATCH, pattern_id: emit_id_wide[3:0],
                             start_position: emit_start_wide[31:0], last: emit_last};
            walk_mask_in = emit_rest;
            rcnt_in      = rcnt_ff + RCNT_W'(1);
            nd_raddr     = walk_dict_ff;
            if (emit_last) pos_in = pos_ff + POSITION_BITS'(1);
         end
         ST_B_POP: begin
            q_raddr = head_ff[NODE_W-1:0];
            if (head_ff < tail_ff) head_in = head_ff + NCNT_W'(1);
            else                   built_in = 1'b1;
         end
         ST_B_PARENT: begin
            cur_in = q_rdata;
         end
         ST_B_SUFP: begin
            sym_in    = par_sym;
            suf_raddr = par_node;
            idx_in    = '0;
            if (!link_needed) begin
               lnk_in     = '0;
               link_we    = 1'b1;
               suf_wdata  = '0;
               dict_wdata = '0;
            end
         end
         ST_B_LNK_RD: begin
            goto_raddr = goto_addr(suf_rdata, sym_ff);
         end
         ST_B_LNK: begin
            lnk_in   = goto_child;
            nd_raddr = goto_child;
            if (goto_child == '0) begin
               link_we    = 1'b1;
               suf_wdata  = '0;
               dict_wdata = '0;
            end
         end
         ST_B_DICT: begin
            // nearest terminal node on the suffix path
            link_we    = 1'b1;
            suf_wdata  = lnk_ff;
            dict_wdata = (mask_rdata != '0) ? lnk_ff : dict_rdata;
         end
         ST_B_CHILD_RD: begin
            goto_raddr = goto_addr(cur_ff, SYM_W'(idx_ff));
         end
         ST_B_CHILD_CHK: begin
            goto_raddr = goto_addr(lnk_ff, SYM_W'(idx_ff));
            if (goto_valid) begin
               if (32'(tail_ff) < MAX_NODES) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + NCNT_W'(1);
               end
               idx_in = idx_ff + SCNT_W'(1);
            end else if (cur_ff == '0) begin
               goto_we    = 1'b1;
               goto_wdata = {1'b1, NODE_W'(0)};
               idx_in     = idx_ff + SCNT_W'(1);
            end
         end
         ST_B_FILL: begin
            goto_we    = 1'b1;
            goto_wdata = {1'b1, goto_child};
            idx_in     = idx_ff + SCNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         sym_valid_ff  <= '0;
         sym_count_ff  <= '0;
         node_count_ff <= NCNT_W'(1);
         pat_count_ff  <= '0;
         ins_node_ff   <= '0;
         ins_len_ff    <= '0;
         built_ff      <= 1'b0;
         auto_ff       <= '0;
         pos_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         rcnt_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         sym_valid_ff  <= sym_valid_in;
         sym_count_ff  <= sym_count_in;
         node_count_ff <= node_count_in;
         pat_count_ff  <= pat_count_in;
         ins_node_ff   <= ins_node_in;
         ins_len_ff    <= ins_len_in;
         built_ff      <= built_in;
         auto_ff       <= auto_in;
         pos_ff        <= pos_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         rcnt_ff       <= rcnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      val_ff       <= val_in;
      sym_ff       <= sym_in;
      cur_ff       <= cur_in;
      lnk_ff       <= lnk_in;
      idx_ff       <= idx_in;
      walk_mask_ff <= walk_mask_in;
      walk_dict_ff <= walk_dict_in;
      rsp_ff       <= rsp_in;
      if (plen_we) begin
         plen_ff[pat_count_ff[PID_W-1:0]] <= ins_len_ff;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/ac_ram.sv
`timescale 1ns / 1ps

module ac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/ac_checker.sv
`timescale 1ns / 1ps

module ac_checker
   import ac_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   // an accepted command makes the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after accepted beat");

   // an error is a single beat
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_MATCH) |-> rsp_data.last)
      else $error("error beat without last");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_MATCH) |->
      (rsp_data.pattern_id == '0 && rsp_data.start_position == '0))
      else $error("error beat with nonzero fields");

   // a new item cannot produce a result the cycle after a last beat
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("result beat right after last");

endmodule

bind aho_corasick_matcher_top ac_checker u_ac_checker (.*);
